// File: src/bounded_set_min_gap_and_range_unit_assert.svh
// Assertion macros for the bounded set min gap / range unit.
// Included by the top level; no other dependencies.
`ifndef BOUNDED_SET_MIN_GAP_AND_RANGE_UNIT_ASSERT_SVH
`define BOUNDED_SET_MIN_GAP_AND_RANGE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BSMG_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define BSMG_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define BSMG_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define BSMG_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/bsmg_pkg.sv
// Shared types and constants for the bounded set min gap / range unit.
// No dependencies.
package bsmg_pkg;

   localparam int DATA_W   = 32;
   localparam int CAP_W    = 7;
   localparam int STATUS_W = 2;

   localparam logic [CAP_W-1:0]    CAP_RESET   = 7'd64;
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FEW  = 2'd2;
   localparam logic                ACT_ADD     = 1'b0;
   localparam logic                ACT_QUERY   = 1'b1;

   typedef struct packed {
      logic              action;
      logic [DATA_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   shortest_gap;
      logic [DATA_W-1:0]   longest_gap;
   } rsp_payload_type;

   // broadcast to every cell
   typedef struct packed {
      logic              ins;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

   // handed from a cell to its right neighbor
   typedef struct packed {
      logic              fill_ok;
      logic              held;
      logic              gt;
      logic [DATA_W-1:0] val;
      logic [DATA_W-1:0] min_gap;
      logic [DATA_W-1:0] last;
   } cell_link_type;

endpackage

// File: src/bsmg_chan_if.sv
// Valid/ready channel interface carrying one payload per transaction.
// Payload type is set per instance; no other dependencies.
interface bsmg_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/bsmg_cell.sv
// One slot of the sorted chain: holds a value, shifts right on insert,
// and folds its neighbor gap and the last held value down the chain.
// Depends on bsmg_pkg.
module bsmg_cell import bsmg_pkg::*; (
   input  logic          clock,
   input  cell_cmd_type  cmd,
   input  logic          occ,
   input  cell_link_type left,
   output cell_link_type right
);

   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] min_ff, min_in;
   logic [DATA_W-1:0] last_ff, last_in;
   logic [DATA_W-1:0] diff;
   logic              gt;
   logic              take;

   always_comb begin
      gt      = occ && (val_ff > cmd.value);
      take    = cmd.ins && (gt || (!occ && left.fill_ok));
      val_in  = take ? (left.gt ? left.val : cmd.value) : val_ff;
      diff    = val_ff - left.val;
      min_in  = (occ && left.held && (diff < left.min_gap)) ? diff : left.min_gap;
      last_in = occ ? val_ff : left.last;
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      min_ff  <= min_in;
      last_ff <= last_in;
   end

   always_comb begin
      right.fill_ok = occ;
      right.held    = occ;
      right.gt      = gt;
      right.val     = val_ff;
      right.min_gap = min_ff;
      right.last    = last_ff;
   end

endmodule

// File: src/bounded_set_min_gap_and_range_unit.sv
// Bounded multiset of 32-bit values kept sorted in a chain of MAX_ENTRIES cells.
// On an add every cell compares in parallel and the larger values shift one
// cell right. A query with two or more values held runs a scan while the gap
// minimum and the last held value ripple through the registered chain; a
// query with fewer values or an add answers without a scan. Results leave
// through an output register, so an add can be taken every cycle while the
// consumer keeps up and no scan is in progress. Depends on bsmg_pkg,
// bsmg_chan_if, bsmg_cell and the assertion macro header.
`include "bounded_set_min_gap_and_range_unit_assert.svh"

module bounded_set_min_gap_and_range_unit import bsmg_pkg::*; #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   bsmg_chan_if.sink        req_chan,
   bsmg_chan_if.source      rsp_chan,
   input  logic             csr_write_enable,
   input  logic [CAP_W-1:0] csr_write_data
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int WW = (CW > CAP_W) ? CW : CAP_W;
   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
   localparam logic [CW-1:0] CNT_TWO = CW'(2);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     scan_ff, scan_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic              req_accept;
   logic              out_free;
   logic              full;
   logic              load;
   cell_cmd_type      cmd;
   logic [MAX_ENTRIES-1:0] occ;
   cell_link_type     links [MAX_ENTRIES+1];

   assign links[0] = '{fill_ok: 1'b1, held: 1'b0, gt: 1'b0, val: '0,
                       min_gap: '1, last: '0};

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      assign occ[i] = (count_ff > CW'(i));
      bsmg_cell u_cell (
         .clock (clock),
         .cmd   (cmd),
         .occ   (occ[i]),
         .left  (links[i]),
         .right (links[i+1])
      );
   end

   always_comb begin
      out_free       = !rsp_valid_ff || rsp_chan.ready;
      req_chan.ready = (state_ff == ST_IDLE) && out_free;
      req_accept     = req_chan.valid && req_chan.ready;
      full           = (WW'(count_ff) >= WW'(cap_ff)) || (count_ff == CNT_MAX);
      cmd.ins        = req_accept && (req_chan.payload.action == ACT_ADD) && !full;
      cmd.value      = req_chan.payload.value;
      count_in       = cmd.ins ? count_ff + 1'b1 : count_ff;
      cap_in         = csr_write_enable ? csr_write_data : cap_ff;

      state_in = state_ff;
      scan_in  = scan_ff;
      load     = 1'b0;
      rsp_in   = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.payload.action == ACT_ADD) begin
                  load   = 1'b1;
                  rsp_in = '{status: full ? STATUS_FULL : STATUS_OK,
                             shortest_gap: '0, longest_gap: '0};
               end else if (count_ff < CNT_TWO) begin
                  load   = 1'b1;
                  rsp_in = '{status: STATUS_FEW, shortest_gap: '0, longest_gap: '0};
               end else begin
                  state_in = ST_SCAN;
                  scan_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == CNT_MAX) begin
               state_in = ST_IDLE;
               load     = 1'b1;
               rsp_in   = '{status: STATUS_OK,
                            shortest_gap: links[MAX_ENTRIES].min_gap,
                            longest_gap: links[MAX_ENTRIES].last - links[1].val};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   `BSMG_ASSERT_NEXT(a_add_grows, clock, reset, cmd.ins, count_ff == $past(count_ff) + 1'b1)
   `BSMG_ASSERT_NOW(a_scan_blocks, clock, reset, state_ff == ST_SCAN, !req_chan.ready)
   `BSMG_ASSERT_NEXT(a_scan_ends, clock, reset, (state_ff == ST_SCAN) && (scan_ff == CNT_MAX), rsp_valid_ff && (state_ff == ST_IDLE))
   `BSMG_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_MAX)

endmodule
